/* rtl/jtp_pkg.sv */
package jtp_pkg;

    // Component format: signed Q2.13, real part in the upper half of a packed word
    localparam int COMP_W    = 16;
    localparam int FRAC_W    = COMP_W - 3;
    localparam int CPLX_W    = 2 * COMP_W;

    // Intermediate L*M element: sum of four 16x16 products, kept exact
    localparam int T_W       = 2 * COMP_W + 2;
    // Final accumulator: sum of four T_W x COMP_W products, kept exact
    localparam int ACC_W     = T_W + COMP_W + 2;

    // Rounding drops 2*FRAC_W fraction bits
    localparam int RND_SHIFT = 2 * FRAC_W;
    localparam int RND_W     = ACC_W - RND_SHIFT;

    // Carried right matrix, four packed elements
    localparam int RMAT_W    = 4 * CPLX_W;

    typedef struct packed {
        logic [CPLX_W-1:0] left_11;
        logic [CPLX_W-1:0] left_12;
        logic [CPLX_W-1:0] left_21;
        logic [CPLX_W-1:0] left_22;
        logic [CPLX_W-1:0] mid_11;
        logic [CPLX_W-1:0] mid_12;
        logic [CPLX_W-1:0] mid_21;
        logic [CPLX_W-1:0] mid_22;
        logic [CPLX_W-1:0] right_11;
        logic [CPLX_W-1:0] right_12;
        logic [CPLX_W-1:0] right_21;
        logic [CPLX_W-1:0] right_22;
    } mats_t;

    typedef struct packed {
        logic [CPLX_W-1:0] prod_11;
        logic [CPLX_W-1:0] prod_12;
        logic [CPLX_W-1:0] prod_21;
        logic [CPLX_W-1:0] prod_22;
        logic              saturated;
    } prod_t;

endpackage

/* rtl/jtp_mat_mul.sv */
module jtp_mat_mul #(
    parameter int AW = 16,
    parameter int BW = 16,
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [AW-1:0] a_re [4],
    input  logic signed [AW-1:0] a_im [4],
    input  logic signed [BW-1:0] b_re [4],
    input  logic signed [BW-1:0] b_im [4],
    input  logic [SW-1:0]        side_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [AW+BW+1:0] c_re [4],
    output logic signed [AW+BW+1:0] c_im [4],
    output logic [SW-1:0]        side_out
);

    localparam int PW = AW + BW;
    localparam int OW = PW + 2;

    // Product index: (element*2 + j)*4 + term, term 0 rr, 1 ii, 2 ri, 3 ir
    logic signed [PW-1:0] prod_next [32];
    logic signed [PW-1:0] prod_reg  [32];
    logic [SW-1:0]        pside_reg;
    logic                 pvalid_reg;

    logic signed [OW-1:0] cre_next [4];
    logic signed [OW-1:0] cim_next [4];
    logic signed [OW-1:0] cre_reg  [4];
    logic signed [OW-1:0] cim_reg  [4];
    logic [SW-1:0]        cside_reg;
    logic                 cvalid_reg;

    logic en_p;
    logic en_c;

    // Stage enables: a stage loads when empty or when its successor moves
    assign en_c     = !cvalid_reg || out_ready;
    assign en_p     = !pvalid_reg || en_c;
    assign in_ready = en_p;

    // Stage 1: all partial products of the 2x2 complex product
    always_comb
    begin
        for (int e = 0; e < 4; e++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                prod_next[(e*2+j)*4+0] = a_re[(e>>1)*2+j] * b_re[j*2+(e&1)];
                prod_next[(e*2+j)*4+1] = a_im[(e>>1)*2+j] * b_im[j*2+(e&1)];
                prod_next[(e*2+j)*4+2] = a_re[(e>>1)*2+j] * b_im[j*2+(e&1)];
                prod_next[(e*2+j)*4+3] = a_im[(e>>1)*2+j] * b_re[j*2+(e&1)];
            end
        end
    end

    // Stage 2: exact sums per element
    always_comb
    begin
        for (int e = 0; e < 4; e++)
        begin
            cre_next[e] = OW'(prod_reg[e*8+0]) - OW'(prod_reg[e*8+1])
                        + OW'(prod_reg[e*8+4]) - OW'(prod_reg[e*8+5]);
            cim_next[e] = OW'(prod_reg[e*8+2]) + OW'(prod_reg[e*8+3])
                        + OW'(prod_reg[e*8+6]) + OW'(prod_reg[e*8+7]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            cvalid_reg <= 1'b0;
        end
        else
        begin
            if (en_p)
            begin
                pvalid_reg <= in_valid;
            end
            if (en_c)
            begin
                cvalid_reg <= pvalid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en_p)
        begin
            prod_reg  <= prod_next;
            pside_reg <= side_in;
        end
        if (en_c)
        begin
            cre_reg   <= cre_next;
            cim_reg   <= cim_next;
            cside_reg <= pside_reg;
        end
    end

    assign out_valid = cvalid_reg;
    assign c_re      = cre_reg;
    assign c_im      = cim_reg;
    assign side_out  = cside_reg;

endmodule

/* rtl/jtp_round_sat.sv */
module jtp_round_sat (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [jtp_pkg::ACC_W-1:0] acc_re [4],
    input  logic signed [jtp_pkg::ACC_W-1:0] acc_im [4],
    output logic                out_valid,
    input  logic                out_ready,
    output jtp_pkg::prod_t      prod
);

    import jtp_pkg::*;

    localparam logic signed [ACC_W-1:0] BIAS =
        {{(ACC_W-RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT-1){1'b0}}};
    localparam logic signed [RND_W-1:0] MAXV =
        {{(RND_W-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
    localparam logic signed [RND_W-1:0] MINV =
        {{(RND_W-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};

    // Round half up, then clip; returns {clipped, component}
    function automatic logic [COMP_W:0] rnd_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] biased;
        logic signed [RND_W-1:0] r;
        logic                    sat;
        logic [COMP_W-1:0]       c;
        biased = v + BIAS;
        r      = RND_W'(biased >>> RND_SHIFT);
        sat    = 1'b0;
        c      = r[COMP_W-1:0];
        if (r > MAXV)
        begin
            sat = 1'b1;
            c   = MAXV[COMP_W-1:0];
        end
        else if (r < MINV)
        begin
            sat = 1'b1;
            c   = MINV[COMP_W-1:0];
        end
        return {sat, c};
    endfunction

    logic [COMP_W:0] re_rs [4];
    logic [COMP_W:0] im_rs [4];
    prod_t           prod_next;
    prod_t           prod_reg;
    logic            valid_reg;
    logic            en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // Round and clip all eight components
    always_comb
    begin
        for (int e = 0; e < 4; e++)
        begin
            re_rs[e] = rnd_sat(acc_re[e]);
            im_rs[e] = rnd_sat(acc_im[e]);
        end
        prod_next.prod_11   = {re_rs[0][COMP_W-1:0], im_rs[0][COMP_W-1:0]};
        prod_next.prod_12   = {re_rs[1][COMP_W-1:0], im_rs[1][COMP_W-1:0]};
        prod_next.prod_21   = {re_rs[2][COMP_W-1:0], im_rs[2][COMP_W-1:0]};
        prod_next.prod_22   = {re_rs[3][COMP_W-1:0], im_rs[3][COMP_W-1:0]};
        prod_next.saturated = re_rs[0][COMP_W] | im_rs[0][COMP_W]
                            | re_rs[1][COMP_W] | im_rs[1][COMP_W]
                            | re_rs[2][COMP_W] | im_rs[2][COMP_W]
                            | re_rs[3][COMP_W] | im_rs[3][COMP_W];
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

/* rtl/jones_2x2_complex_triple_product.sv */
// Product P = L*M*R of three 2x2 complex matrices, one grid cell per transaction.
// Elements are packed complex Q2.13 (real in bits 31:16, imaginary in 15:0). L*M is
// kept exact, the final elements are rounded half up and clipped, and saturated flags
// any clipped component. The block takes one transaction every cycle while the output is
// not stalled. There are five register stages: two for the L*M products and sums, two for
// the T*R products and sums, and the round-and-clip output register.
// Stalls on the output fill empty stages first, then hold the pipeline without loss.
module jones_2x2_complex_triple_product (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mats_valid,
    output logic           mats_ready,
    input  jtp_pkg::mats_t mats,
    output logic           prod_valid,
    input  logic           prod_ready,
    output jtp_pkg::prod_t prod
);

    import jtp_pkg::*;

    logic signed [COMP_W-1:0] l_re [4];
    logic signed [COMP_W-1:0] l_im [4];
    logic signed [COMP_W-1:0] m_re [4];
    logic signed [COMP_W-1:0] m_im [4];
    logic signed [COMP_W-1:0] r_re [4];
    logic signed [COMP_W-1:0] r_im [4];
    logic [CPLX_W-1:0]        l_pk [4];
    logic [CPLX_W-1:0]        m_pk [4];
    logic [RMAT_W-1:0]        r_side;
    logic [RMAT_W-1:0]        r_side_dly;

    logic signed [T_W-1:0]    t_re [4];
    logic signed [T_W-1:0]    t_im [4];
    logic                     t_valid;
    logic                     t_ready;

    logic signed [ACC_W-1:0]  acc_re [4];
    logic signed [ACC_W-1:0]  acc_im [4];
    logic                     acc_valid;
    logic                     acc_ready;

    // Unpack input elements; R travels alongside the first multiply
    assign l_pk   = '{mats.left_11, mats.left_12, mats.left_21, mats.left_22};
    assign m_pk   = '{mats.mid_11, mats.mid_12, mats.mid_21, mats.mid_22};
    assign r_side = {mats.right_11, mats.right_12, mats.right_21, mats.right_22};

    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            l_re[n] = l_pk[n][CPLX_W-1:COMP_W];
            l_im[n] = l_pk[n][COMP_W-1:0];
            m_re[n] = m_pk[n][CPLX_W-1:COMP_W];
            m_im[n] = m_pk[n][COMP_W-1:0];
            r_re[n] = r_side_dly[(3-n)*CPLX_W+COMP_W +: COMP_W];
            r_im[n] = r_side_dly[(3-n)*CPLX_W +: COMP_W];
        end
    end

    // T = L*M, exact
    jtp_mat_mul #(
        .AW (COMP_W),
        .BW (COMP_W),
        .SW (RMAT_W)
    ) u_lm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mats_valid),
        .in_ready  (mats_ready),
        .a_re      (l_re),
        .a_im      (l_im),
        .b_re      (m_re),
        .b_im      (m_im),
        .side_in   (r_side),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .c_re      (t_re),
        .c_im      (t_im),
        .side_out  (r_side_dly)
    );

    // T*R, exact
    jtp_mat_mul #(
        .AW (T_W),
        .BW (COMP_W),
        .SW (1)
    ) u_tr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .a_re      (t_re),
        .a_im      (t_im),
        .b_re      (r_re),
        .b_im      (r_im),
        .side_in   (1'b0),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .c_re      (acc_re),
        .c_im      (acc_im),
        .side_out  ()
    );

    // Round, clip and register the result
    jtp_round_sat u_rs (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .acc_re    (acc_re),
        .acc_im    (acc_im),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .prod      (prod)
    );

endmodule

/* rtl/jtp_checker.sv */
module jtp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           mats_valid,
    input logic           mats_ready,
    input logic           prod_valid,
    input logic           prod_ready,
    input jtp_pkg::prod_t prod
);

    import jtp_pkg::*;

    localparam logic [COMP_W-1:0] CMAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic [COMP_W-1:0] CMIN = {1'b1, {(COMP_W-1){1'b0}}};

    // A stalled result holds
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid && !prod_ready |=> prod_valid && $stable(prod))
        else $error("result changed while stalled");

    // With the output draining, the pipeline never refuses a transaction
    a_no_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        prod_ready |-> mats_ready)
        else $error("input refused while output drains");

    // An accepted transaction reaches the output when the output is not stalled meanwhile
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (mats_valid && mats_ready && prod_ready ##1 prod_ready ##1 prod_ready
         ##1 prod_ready ##1 prod_ready) |=> prod_valid)
        else $error("result missing after pipeline latency");

    // A clipped result must have a component at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid && prod.saturated |->
            prod.prod_11[CPLX_W-1:COMP_W] == CMAX || prod.prod_11[CPLX_W-1:COMP_W] == CMIN ||
            prod.prod_11[COMP_W-1:0] == CMAX || prod.prod_11[COMP_W-1:0] == CMIN ||
            prod.prod_12[CPLX_W-1:COMP_W] == CMAX || prod.prod_12[CPLX_W-1:COMP_W] == CMIN ||
            prod.prod_12[COMP_W-1:0] == CMAX || prod.prod_12[COMP_W-1:0] == CMIN ||
            prod.prod_21[CPLX_W-1:COMP_W] == CMAX || prod.prod_21[CPLX_W-1:COMP_W] == CMIN ||
            prod.prod_21[COMP_W-1:0] == CMAX || prod.prod_21[COMP_W-1:0] == CMIN ||
            prod.prod_22[CPLX_W-1:COMP_W] == CMAX || prod.prod_22[CPLX_W-1:COMP_W] == CMIN ||
            prod.prod_22[COMP_W-1:0] == CMAX || prod.prod_22[COMP_W-1:0] == CMIN)
        else $error("saturated set with no component at a limit");

endmodule

bind jones_2x2_complex_triple_product jtp_checker u_jtp_checker (.*);

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jtp_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 265;
    localparam int unsigned BURST_ITEMS     = 40;
    localparam int unsigned HOLDOFF_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES    = 20;

    // Q2.13 landmarks
    localparam logic [COMP_W-1:0] COMP_MAX = 16'h7FFF;
    localparam logic [COMP_W-1:0] COMP_MIN = 16'h8000;
    localparam logic [COMP_W-1:0] COMP_ONE = 16'h2000;

    typedef struct {
        mats_t mset;
        bit    typed;
        prod_t want;
    } stim_row_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  mats_valid;
    logic  mats_ready;
    mats_t mats;
    logic  prod_valid;
    logic  prod_ready;
    prod_t prod;

    prod_t       expected_prods[$];
    stim_row_t   stim_rows[$];
    int unsigned failures = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned holdoff_seq = 0;

    // sender idle / receiver stall percentages per phase
    int unsigned phase_tx_idle[4]  = '{0, 82, 0, 35};
    int unsigned phase_rx_stall[4] = '{0, 0, 82, 35};

    jones_2x2_complex_triple_product dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .mats_valid (mats_valid),
        .mats_ready (mats_ready),
        .mats       (mats),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    always #4 clk = ~clk;

    // Round half up by 2*FRAC_W bits, clip to the component range; MSB flags a clip
    function automatic logic [COMP_W:0] round_clip(input longint acc);
        longint top;
        longint bot;
        longint v;
        top = (longint'(1) <<< (COMP_W - 1)) - 1;
        bot = -(longint'(1) <<< (COMP_W - 1));
        v = (acc + (longint'(1) <<< (2 * FRAC_W - 1))) >>> (2 * FRAC_W);
        if (v > top)
            return {1'b1, top[COMP_W-1:0]};
        if (v < bot)
            return {1'b1, bot[COMP_W-1:0]};
        return {1'b0, v[COMP_W-1:0]};
    endfunction

    // L*M kept exact, then (L*M)*R rounded and clipped per component
    function automatic prod_t triple_product(input mats_t c);
        logic [CPLX_W-1:0] lw[4];
        logic [CPLX_W-1:0] mw[4];
        logic [CPLX_W-1:0] rw[4];
        longint            lre[4], lim[4], mre[4], mim[4], rre[4], rim[4];
        longint            tre[4], tim[4];
        longint            are, aim;
        logic [COMP_W:0]   cre, cim;
        logic [CPLX_W-1:0] elem[4];
        logic              sat;
        lw = '{c.left_11, c.left_12, c.left_21, c.left_22};
        mw = '{c.mid_11, c.mid_12, c.mid_21, c.mid_22};
        rw = '{c.right_11, c.right_12, c.right_21, c.right_22};
        sat = 1'b0;
        for (int n = 0; n < 4; n++)
        begin
            lre[n] = longint'($signed(lw[n][CPLX_W-1:COMP_W]));
            lim[n] = longint'($signed(lw[n][COMP_W-1:0]));
            mre[n] = longint'($signed(mw[n][CPLX_W-1:COMP_W]));
            mim[n] = longint'($signed(mw[n][COMP_W-1:0]));
            rre[n] = longint'($signed(rw[n][CPLX_W-1:COMP_W]));
            rim[n] = longint'($signed(rw[n][COMP_W-1:0]));
        end
        // T = L*M, full precision
        for (int i = 0; i < 2; i++)
            for (int k = 0; k < 2; k++)
            begin
                tre[i*2+k] = 0;
                tim[i*2+k] = 0;
                for (int j = 0; j < 2; j++)
                begin
                    tre[i*2+k] += lre[i*2+j] * mre[j*2+k] - lim[i*2+j] * mim[j*2+k];
                    tim[i*2+k] += lre[i*2+j] * mim[j*2+k] + lim[i*2+j] * mre[j*2+k];
                end
            end
        // P = T*R, then round and clip
        for (int i = 0; i < 2; i++)
            for (int k = 0; k < 2; k++)
            begin
                are = 0;
                aim = 0;
                for (int j = 0; j < 2; j++)
                begin
                    are += tre[i*2+j] * rre[j*2+k] - tim[i*2+j] * rim[j*2+k];
                    aim += tre[i*2+j] * rim[j*2+k] + tim[i*2+j] * rre[j*2+k];
                end
                cre = round_clip(are);
                cim = round_clip(aim);
                sat |= cre[COMP_W] | cim[COMP_W];
                elem[i*2+k] = {cre[COMP_W-1:0], cim[COMP_W-1:0]};
            end
        return {elem[0], elem[1], elem[2], elem[3], sat};
    endfunction

    // Random width component, with the odd landmark value thrown in
    function automatic logic [COMP_W-1:0] random_component(input int unsigned wmax);
        logic signed [COMP_W-1:0] v;
        int unsigned              w;
        w = $urandom_range(wmax, 1);
        v = COMP_W'($urandom);
        case ($urandom_range(19))
            0: v = COMP_MAX;
            1: v = COMP_MIN;
            2: v = '0;
            3: v = COMP_ONE;
            4: v = -COMP_ONE;
            default: v = (v <<< (COMP_W - w)) >>> (COMP_W - w);
        endcase
        return v;
    endfunction

    // Mostly bounded magnitudes so that both clipped and unclipped products occur
    function automatic mats_t random_cell();
        logic [CPLX_W-1:0] w[12];
        int unsigned       wmax;
        wmax = $urandom_range(COMP_W, 2);
        for (int n = 0; n < 12; n++)
            if ($urandom_range(7) == 0)
                w[n] = $urandom;
            else
                w[n] = {random_component(wmax), random_component(wmax)};
        return {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9], w[10], w[11]};
    endfunction

    function automatic mats_t diag_cell(input logic [CPLX_W-1:0] l, m, r);
        mats_t c;
        c = '0;
        c.left_11  = l;
        c.left_22  = l;
        c.mid_11   = m;
        c.mid_22   = m;
        c.right_11 = r;
        c.right_22 = r;
        return c;
    endfunction

    task automatic add_row(input mats_t mset, input bit typed, input prod_t want);
        stim_row_t row;
        row.mset  = mset;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // Offer one transaction, hold until taken, then idle at random
    task automatic offer_cell(input mats_t mset, input prod_t want);
        mats       <= mset;
        mats_valid <= 1'b1;
        do @(posedge clk); while (!mats_ready);
        expected_prods.push_back(want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            mats_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_prods.size() != 0)
            @(posedge clk);
    endtask

    task automatic cmp_field(input string name, input logic [CPLX_W-1:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
        end
    endtask

    task automatic check_prod(input prod_t got);
        prod_t want;
        if (expected_prods.size() == 0)
        begin
            $error("unexpected product transaction %h", got);
            failures++;
            return;
        end
        want = expected_prods.pop_front();
        cmp_field("prod_11", want.prod_11, got.prod_11);
        cmp_field("prod_12", want.prod_12, got.prod_12);
        cmp_field("prod_21", want.prod_21, got.prod_21);
        cmp_field("prod_22", want.prod_22, got.prod_22);
        cmp_field("saturated", CPLX_W'(want.saturated), CPLX_W'(got.saturated));
    endtask

    // Receiver: check accepted products, stall at random, long hold-off on request
    initial
    begin
        int unsigned hold_left;
        int unsigned seen_seq;
        hold_left  = 0;
        seen_seq   = 0;
        prod_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && prod_valid && prod_ready)
                check_prod(prod);
            if (holdoff_seq != seen_seq)
            begin
                seen_seq  = holdoff_seq;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                prod_ready <= 1'b0;
            end
            else
                prod_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        mats_t mset;
        rst_n      = 1'b0;
        mats_valid = 1'b0;
        mats       = '0;

        // directed table; typed rows are read straight off the arithmetic
        add_row('0, 1'b1, '0);
        // identity cubed
        add_row(diag_cell(32'h20000000, 32'h20000000, 32'h20000000), 1'b1,
                {32'h20000000, 32'h0, 32'h0, 32'h20000000, 1'b0});
        // all components most negative: real clips high, imaginary clips low
        add_row(mats_t'({12{32'h80008000}}), 1'b1, {{4{32'h7FFF8000}}, 1'b1});
        // all components most positive: real clips low, imaginary clips high
        add_row(mats_t'({12{32'h7FFF7FFF}}), 1'b1, {{4{32'h80007FFF}}, 1'b1});
        // half-LSB ties round up, negative tie lands on zero
        mset = '0;
        mset.left_11  = 32'h10000000;
        mset.mid_11   = 32'h20000000;
        mset.right_11 = 32'h00010000;
        add_row(mset, 1'b1, {32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0});
        mset.right_11 = 32'h00000001;
        add_row(mset, 1'b1, {32'h00000001, 32'h0, 32'h0, 32'h0, 1'b0});
        mset.right_11 = 32'hFFFF0000;
        add_row(mset, 1'b1, '0);
        // identity L and M pass R through untouched, extremes included
        mset = diag_cell(32'h20000000, 32'h20000000, 32'h0);
        mset.right_11 = 32'h7FFF0000;
        mset.right_12 = 32'h00007FFF;
        mset.right_21 = 32'h80000000;
        mset.right_22 = 32'h00008000;
        add_row(mset, 1'b1, {32'h7FFF0000, 32'h00007FFF, 32'h80000000, 32'h00008000, 1'b0});
        add_row(mats_t'({12{32'hFFFFFFFF}}), 1'b0, '0);
        add_row(mats_t'({12{32'h00002000}}), 1'b0, '0);
        add_row(mats_t'({12{32'h20000000}}), 1'b0, '0);
        add_row(mats_t'({12{32'hAAAA5555}}), 1'b0, '0);
        add_row(mats_t'({12{32'h5555AAAA}}), 1'b0, '0);
        add_row(diag_cell(32'h40000000, 32'h00002000, 32'hE0002000), 1'b0, '0);
        add_row(mats_t'({32'h12345678, 32'h9ABCDEF0, 32'h0F1E2D3C, 32'hF0E1D2C3,
                         32'h01000100, 32'hFF00FF00, 32'h00FF8001, 32'h7F0180FE,
                         32'h10101010, 32'hEFEFEFEF, 32'h3FFFC000, 32'hC0003FFF}),
                1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct  = phase_tx_idle[0];
        rx_stall_pct = phase_rx_stall[0];
        foreach (stim_rows[n])
            offer_cell(stim_rows[n].mset,
                       stim_rows[n].typed ? stim_rows[n].want : triple_product(stim_rows[n].mset));

        // receiver holds off while transactions keep coming: pipeline fills and stalls
        holdoff_seq++;
        repeat (BURST_ITEMS)
        begin
            mset = random_cell();
            offer_cell(mset, triple_product(mset));
        end
        mats_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            tx_idle_pct  = phase_tx_idle[p];
            rx_stall_pct = phase_rx_stall[p];
            repeat (ITEMS_PER_PHASE)
            begin
                mset = random_cell();
                offer_cell(mset, triple_product(mset));
            end
            mats_valid <= 1'b0;
            wait_drained();
        end

        // let any stray product surface
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
